@@ rtl/cal_pkg.sv @@
// ============================================================================
// cal_pkg
// Shared types, constants and calendar helper functions for the Gregorian
// date counter.
// ============================================================================
package cal_pkg;

    // Width of the advance day counter; the whole request count field.
    localparam int CountWidth = 16;

    localparam logic [13:0] YearMax    = 14'd9999;
    localparam logic [8:0]  DaysLeap   = 9'd366;
    localparam logic [8:0]  DaysCommon = 9'd365;
    localparam logic [13:0] CentDiv    = 14'd100;
    localparam logic [6:0]  CentLast   = 7'd99;
    localparam logic [3:0]  MonthDec   = 4'd12;
    localparam logic [2:0]  WdaySat    = 3'd6;
    localparam logic [2:0]  WdayUnk    = 3'd7;

    // Reciprocal of 100 for the century split: floor(y / 100) = (y * 5243) >> 19
    // for every fourteen-bit year.
    localparam logic [26:0] CentRecip  = 27'd5243;
    localparam int          CentShift  = 19;

    // Request kinds carried in the slave-side tuser.
    localparam logic ReqSet     = 1'b0;
    localparam logic ReqAdvance = 1'b1;

    localparam logic StatusOk  = 1'b0;
    localparam logic StatusBad = 1'b1;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        logic [2:0]  wday;
        logic        leap;
        logic [6:0]  yy;   // year modulo 100
        logic [6:0]  cc;   // year divided by 100
    } t_date;

    function automatic logic is_leap(input logic [6:0] yy, input logic [6:0] cc);
        is_leap = (yy[1:0] == 2'd0) && ((yy != 7'd0) || (cc[1:0] == 2'd0));
    endfunction

    // Length of month m; codes outside 1..12 give zero.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
            4'd2:                                       month_len = leap ? 5'd29 : 5'd28;
            default:                                    month_len = 5'd0;
        endcase
    endfunction

    // Month offsets of the weekday formula, with January and February shifted
    // back by one in a leap year.
    function automatic logic [2:0] month_code(input logic [3:0] m, input logic leap);
        case (m)
            4'd1:    month_code = leap ? 3'd6 : 3'd0;
            4'd2:    month_code = leap ? 3'd2 : 3'd3;
            4'd3:    month_code = 3'd3;
            4'd4:    month_code = 3'd6;
            4'd5:    month_code = 3'd1;
            4'd6:    month_code = 3'd4;
            4'd7:    month_code = 3'd6;
            4'd8:    month_code = 3'd2;
            4'd9:    month_code = 3'd5;
            4'd10:   month_code = 3'd0;
            4'd11:   month_code = 3'd3;
            4'd12:   month_code = 3'd5;
            default: month_code = 3'd0;
        endcase
    endfunction

    // Remainder by seven of an eight-bit value. Since 64 and 8 are both one
    // more than a multiple of seven, digit folding keeps the residue.
    function automatic logic [2:0] mod7(input logic [7:0] x);
        logic [6:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 7'(x[7:6]) + 7'(x[5:0]);
        s2 = 4'(s1[6:3]) + 4'(s1[2:0]);
        s3 = 4'(s2[3]) + 4'(s2[2:0]);
        mod7 = (s3 >= 4'd7) ? 3'(s3 - 4'd7) : s3[2:0];
    endfunction

endpackage

@@ rtl/cal_day_step.sv @@
// ============================================================================
// cal_day_step
// Next-day logic: moves a fully known date on by one day, rolling over the
// month and the year and keeping the century split and leap bit in step.
// ============================================================================
module cal_day_step (
    input  cal_pkg::t_date i_date,
    output cal_pkg::t_date o_date
);

    logic [8:0]  w_len_year;
    logic        w_year_end;
    logic [13:0] w_year_nx;
    logic [6:0]  w_yy_nx;
    logic [6:0]  w_cc_nx;

    assign w_len_year = i_date.leap ? cal_pkg::DaysLeap : cal_pkg::DaysCommon;
    assign w_year_end = (i_date.doy >= w_len_year);

    // Year 9999 wraps to year 0, which restarts both halves of the split.
    always_comb begin
        if (i_date.year >= cal_pkg::YearMax) begin
            w_year_nx = 14'd0;
            w_yy_nx   = 7'd0;
            w_cc_nx   = 7'd0;
        end else if (i_date.yy >= cal_pkg::CentLast) begin
            w_year_nx = i_date.year + 14'd1;
            w_yy_nx   = 7'd0;
            w_cc_nx   = i_date.cc + 7'd1;
        end else begin
            w_year_nx = i_date.year + 14'd1;
            w_yy_nx   = i_date.yy + 7'd1;
            w_cc_nx   = i_date.cc;
        end
    end

    always_comb begin
        o_date      = i_date;
        o_date.wday = (i_date.wday >= cal_pkg::WdaySat) ? 3'd0 : i_date.wday + 3'd1;
        if (w_year_end) begin
            o_date.year  = w_year_nx;
            o_date.yy    = w_yy_nx;
            o_date.cc    = w_cc_nx;
            o_date.leap  = cal_pkg::is_leap(w_yy_nx, w_cc_nx);
            o_date.month = 4'd1;
            o_date.day   = 5'd1;
            o_date.doy   = 9'd1;
        end else begin
            if ((i_date.day >= cal_pkg::month_len(i_date.month, i_date.leap))
                    && (i_date.month < cal_pkg::MonthDec)) begin
                o_date.month = i_date.month + 4'd1;
                o_date.day   = 5'd1;
            end else begin
                o_date.day = i_date.day + 5'd1;
            end
            o_date.doy = i_date.doy + 9'd1;
        end
    end

endmodule

@@ rtl/calendar_date_counter.sv @@
// ============================================================================
// calendar_date_counter
// Gregorian date register with day of year, weekday and leap flag.
// ============================================================================
// Requests arrive as beats on the slave stream: tuser selects a set (load the
// date from the fields, with month or day optionally unknown) or an advance
// (step forward by a day count). Every request gives exactly one result beat
// on the master stream showing the stored date afterwards, with tuser set
// when a set was rejected as invalid.
// A set request passes from acceptance to the result register through the
// century split by a reciprocal multiply, the check, a walk that adds one
// month length per cycle through the single day-of-year adder and the weekday
// fold; a set with month or day unknown, or rejected, skips the walk and the
// fold. An advance steps the date by one day per cycle through the next-day
// unit until the count is used up; one with the weekday unknown or a zero
// count goes straight to completion. One request is handled at a time; tready
// is high only while idle. A finished result sits in the output register, so
// the next request is taken while it waits; if the receiver still stalls when
// the next result is ready, the sequencer holds until the register is free.
// Reset clears the date to year 0, month, day and weekday unknown, leap set.
// ============================================================================
module calendar_date_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [13:0] year_in, [17:14] month_in, [18] month_unknown, [23:19] day_in,
    // [24] day_unknown, [40:25] advance_days, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    // [0] req_type
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [13:0] year_out, [17:14] month_out, [22:18] day_out,
    // [31:23] day_of_year_out, [34:32] weekday_out, [35] leap_out, [39:36] zero
    output logic [39:0] m_axis_tdata,
    // [0] status
    output logic [0:0]  m_axis_tuser
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_WALK = 7'b0001000,
        S_WDAY = 7'b0010000,
        S_ADV  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;

    cal_pkg::t_date r_cur;
    cal_pkg::t_date r_out;
    cal_pkg::t_date w_step;
    logic           r_out_valid;
    logic           r_out_status;
    logic           r_status;

    // Working copy of the request.
    logic [13:0]                   r_year;
    logic [3:0]                    r_month;
    logic                          r_month_unk;
    logic [4:0]                    r_day;
    logic                          r_day_unk;
    logic [cal_pkg::CountWidth-1:0] r_cnt;
    logic [6:0]                    r_cc;
    logic [6:0]                    r_yy;
    logic                          r_leap;
    logic [3:0]                    r_idx;
    logic [8:0]                    r_doy;

    logic        w_accept;
    logic        w_adv_ok;
    logic [26:0] w_prod;
    logic [13:0] w_rem;
    logic [6:0]  w_yy;
    logic        w_leap;
    logic        w_year_bad;
    logic        w_month_bad;
    logic        w_day_bad;
    logic [7:0]  w_wsum;
    logic        w_out_free;

    cal_day_step u_step (
        .i_date (r_cur),
        .o_date (w_step)
    );

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Advancing needs a full date; a known weekday implies one.
    assign w_adv_ok = (r_cur.wday <= cal_pkg::WdaySat) && (r_cur.month >= 4'd1)
                      && (r_cur.month <= cal_pkg::MonthDec);

    assign w_prod = 27'(r_year) * cal_pkg::CentRecip;
    assign w_rem  = r_year - 14'(r_cc) * cal_pkg::CentDiv;
    assign w_yy   = w_rem[6:0];
    assign w_leap = cal_pkg::is_leap(w_yy, r_cc);

    assign w_year_bad  = (r_year > cal_pkg::YearMax);
    assign w_month_bad = (r_month == 4'd0) || (r_month > cal_pkg::MonthDec);
    assign w_day_bad   = (r_day == 5'd0) || (r_day > cal_pkg::month_len(r_month, w_leap));

    assign w_wsum = 8'(r_day) + 8'(cal_pkg::month_code(r_month, r_leap)) + 8'(r_yy)
                    + 8'(r_yy[6:2]) + 8'(3'd6 - {r_cc[1:0], 1'b0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cur       <= '{year: 14'd0, month: 4'd0, day: 5'd0, doy: 9'd0,
                             wday: cal_pkg::WdayUnk, leap: 1'b1, yy: 7'd0, cc: 7'd0};
        end else begin
            // A beat leaving in the same cycle as the next one is loaded keeps
            // the register full.
            if (m_axis_tvalid && m_axis_tready && !((r_state == S_DONE) && w_out_free)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_year      <= s_axis_tdata[13:0];
                        r_month     <= s_axis_tdata[17:14];
                        r_month_unk <= s_axis_tdata[18];
                        r_day       <= s_axis_tdata[23:19];
                        r_day_unk   <= s_axis_tdata[24];
                        r_cnt       <= s_axis_tdata[25 +: cal_pkg::CountWidth];
                        r_status    <= cal_pkg::StatusOk;
                        if (s_axis_tuser[0] == cal_pkg::ReqSet) begin
                            r_state <= S_DIV;
                        end else if (w_adv_ok
                                && (s_axis_tdata[25 +: cal_pkg::CountWidth] != '0)) begin
                            r_state <= S_ADV;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_cc    <= w_prod[cal_pkg::CentShift +: 7];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_DONE;
                    if (w_year_bad) begin
                        r_status <= cal_pkg::StatusBad;
                    end else if (r_month_unk) begin
                        r_cur <= '{year: r_year, month: 4'd0, day: 5'd0, doy: 9'd0,
                                   wday: cal_pkg::WdayUnk, leap: w_leap, yy: w_yy, cc: r_cc};
                    end else if (w_month_bad) begin
                        r_status <= cal_pkg::StatusBad;
                    end else if (r_day_unk) begin
                        r_cur <= '{year: r_year, month: r_month, day: 5'd0, doy: 9'd0,
                                   wday: cal_pkg::WdayUnk, leap: w_leap, yy: w_yy, cc: r_cc};
                    end else if (w_day_bad) begin
                        r_status <= cal_pkg::StatusBad;
                    end else begin
                        r_leap  <= w_leap;
                        r_yy    <= w_yy;
                        r_doy   <= 9'(r_day);
                        r_idx   <= 4'd1;
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Add the length of each month before the requested one.
                    if (r_idx < r_month) begin
                        r_doy <= r_doy + 9'(cal_pkg::month_len(r_idx, r_leap));
                        r_idx <= r_idx + 4'd1;
                    end else begin
                        r_state <= S_WDAY;
                    end
                end
                S_WDAY: begin
                    r_cur <= '{year: r_year, month: r_month, day: r_day, doy: r_doy,
                               wday: cal_pkg::mod7(w_wsum), leap: r_leap, yy: r_yy,
                               cc: r_cc};
                    r_state <= S_DONE;
                end
                S_ADV: begin
                    r_cur <= w_step;
                    r_cnt <= r_cnt - cal_pkg::CountWidth'(1);
                    if (r_cnt == cal_pkg::CountWidth'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out        <= r_cur;
                        r_out_status <= r_status;
                        r_out_valid  <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out_status;
    assign m_axis_tdata    = {4'd0, r_out.leap, r_out.wday, r_out.doy, r_out.day,
                              r_out.month, r_out.year};

`ifndef ASSERT_OFF
    // A known weekday always comes with a complete date.
    a_full_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.wday != cal_pkg::WdayUnk) |-> ((r_cur.month >= 4'd1)
            && (r_cur.month <= cal_pkg::MonthDec) && (r_cur.day != 5'd0)
            && (r_cur.doy != 9'd0)))
        else $error("weekday known but date incomplete");

    // The ordinal day never runs past the length of the stored year.
    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur.doy <= (r_cur.leap ? cal_pkg::DaysLeap : cal_pkg::DaysCommon)))
        else $error("day of year beyond year length");

    // Stepping only runs with a count left and never flags a rejection.
    a_adv_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) |-> ((r_cnt != '0) && (r_status == cal_pkg::StatusOk)))
        else $error("advance running with empty count or bad status");

    // A result beat is only loaded from the completion state.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside completion");
`endif

endmodule

@@ tb/calendar_date_counter_tb.sv @@
// ============================================================================
// calendar_date_counter_tb
// Self-checking stream testbench for the Gregorian date counter.
// ============================================================================
// Set and advance requests are queued by a stimulus process and sent by a
// clocked driver. The driver predicts the stored date for every accepted
// request beat. A clocked monitor compares every result beat, field by field,
// with the oldest prediction. A directed set of corner dates runs first. It
// is followed by three random phases with different gap and stall patterns,
// one of which holds the result side off for a long stretch.
// ============================================================================
module calendar_date_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        req;
        logic [15:0] count;
        logic        day_unk;
        logic [4:0]  day;
        logic        mon_unk;
        logic [3:0]  month;
        logic [13:0] year;
    } t_date_request;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [8:0]  doy;
        logic [2:0]  wday;
        logic        leap;
    } t_cal_date;

    typedef struct {
        logic      status;
        t_cal_date date;
    } t_date_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [13:0] year_in, [17:14] month_in, [18] month_unknown, [23:19] day_in,
    // [24] day_unknown, [40:25] advance_days, [47:41] zero
    logic [47:0] s_axis_tdata = '0;
    // [0] req_type
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [13:0] year_out, [17:14] month_out, [22:18] day_out,
    // [31:23] day_of_year_out, [34:32] weekday_out, [35] leap_out, [39:36] zero
    logic [39:0] m_axis_tdata;
    // [0] status
    logic [0:0]  m_axis_tuser;

    t_date_request request_q[$];
    t_date_result  expected_dates[$];
    t_date_request sent_req;
    t_cal_date     cal_now;

    int     tx_gap_pct = 0;
    int     rx_stall_pct = 0;
    int     phase_mode = 0;
    logic   rx_hold = 1'b0;
    int     n_fail = 0;
    longint n_cycles = 0;
    longint cycle_budget = 0;

    calendar_date_counter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Calendar arithmetic for the prediction
    // ------------------------------------------------------------------
    function automatic logic gregorian_leap(int y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int month_days(int m, logic leap);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // January and February are one day earlier in a leap year.
    function automatic int month_offset(int m, logic leap);
        case (m)
            1:       return leap ? 6 : 0;
            2:       return leap ? 2 : 3;
            3, 11:   return 3;
            4, 7:    return 6;
            5:       return 1;
            6:       return 4;
            8:       return 2;
            9:       return 5;
            12:      return 5;
            default: return 0;
        endcase
    endfunction

    function automatic void step_day();
        int len_year;
        len_year = cal_now.leap ? 366 : 365;
        cal_now.wday = (cal_now.wday >= cal_pkg::WdaySat) ? 3'd0 : cal_now.wday + 3'd1;
        if (cal_now.doy >= len_year) begin
            cal_now.year  = (cal_now.year >= cal_pkg::YearMax) ? 14'd0 : cal_now.year + 14'd1;
            cal_now.leap  = gregorian_leap(int'(cal_now.year));
            cal_now.month = 4'd1;
            cal_now.day   = 5'd1;
            cal_now.doy   = 9'd1;
        end else begin
            if (cal_now.day >= month_days(int'(cal_now.month), cal_now.leap) &&
                cal_now.month < 4'd12) begin
                cal_now.month = cal_now.month + 4'd1;
                cal_now.day   = 5'd1;
            end else begin
                cal_now.day = cal_now.day + 5'd1;
            end
            cal_now.doy = cal_now.doy + 9'd1;
        end
    endfunction

    function automatic t_date_result predict_date_update(t_date_request rq);
        t_date_result res;
        int   y, m, d, doy, yy, cc, k;
        logic lp;
        res.status = cal_pkg::StatusOk;
        if (rq.req == cal_pkg::ReqSet) begin
            y  = int'(rq.year);
            m  = int'(rq.month);
            d  = int'(rq.day);
            lp = gregorian_leap(y);
            if (y > cal_pkg::YearMax) begin
                res.status = cal_pkg::StatusBad;
            end else if (rq.mon_unk) begin
                cal_now.year  = 14'(y);
                cal_now.leap  = lp;
                cal_now.month = 4'd0;
                cal_now.day   = 5'd0;
                cal_now.doy   = 9'd0;
                cal_now.wday  = cal_pkg::WdayUnk;
            end else if (m < 1 || m > 12) begin
                res.status = cal_pkg::StatusBad;
            end else if (rq.day_unk) begin
                cal_now.year  = 14'(y);
                cal_now.leap  = lp;
                cal_now.month = 4'(m);
                cal_now.day   = 5'd0;
                cal_now.doy   = 9'd0;
                cal_now.wday  = cal_pkg::WdayUnk;
            end else if (d < 1 || d > month_days(m, lp)) begin
                res.status = cal_pkg::StatusBad;
            end else begin
                doy = d;
                for (k = 1; k < m; k++) doy += month_days(k, lp);
                yy = y % 100;
                cc = y / 100;
                cal_now.year  = 14'(y);
                cal_now.leap  = lp;
                cal_now.month = 4'(m);
                cal_now.day   = 5'(d);
                cal_now.doy   = 9'(doy);
                cal_now.wday  = 3'((d + month_offset(m, lp) + yy + yy / 4 +
                                    (6 - 2 * (cc % 4))) % 7);
            end
        end else if (cal_now.wday <= cal_pkg::WdaySat && cal_now.month >= 4'd1 &&
                     cal_now.month <= 4'd12) begin
            for (k = 0; k < int'(rq.count); k++) step_day();
        end
        res.date = cal_now;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request beat at a time from the queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_dates.insert(expected_dates.size(), predict_date_update(sent_req));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_gap_pct) begin
                    sent_req = request_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, sent_req.count, sent_req.day_unk, sent_req.day,
                                      sent_req.mon_unk, sent_req.month, sent_req.year};
                    s_axis_tuser  <= sent_req.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: result beats against the predicted dates
    // ------------------------------------------------------------------
    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dates.size() == 0) begin
                $error("result beat arrived with no request outstanding");
                n_fail++;
            end else begin
                want = expected_dates.pop_front();
                check_field("status",          int'(want.status),     int'(m_axis_tuser[0]));
                check_field("year_out",        int'(want.date.year),  int'(m_axis_tdata[13:0]));
                check_field("month_out",       int'(want.date.month), int'(m_axis_tdata[17:14]));
                check_field("day_out",         int'(want.date.day),   int'(m_axis_tdata[22:18]));
                check_field("day_of_year_out", int'(want.date.doy),   int'(m_axis_tdata[31:23]));
                check_field("weekday_out",     int'(want.date.wday),  int'(m_axis_tdata[34:32]));
                check_field("leap_out",        int'(want.date.leap),  int'(m_axis_tdata[35]));
            end
        end
        m_axis_tready <= i_rst_n && !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > 4 * cycle_budget + 100000) begin
            $display("calendar_date_counter_tb: FAIL");
            $finish;
        end
    end

    // In the last phase the result side stops for a long stretch, so the block
    // holds one result, takes one more request and then backs up the input.
    initial begin
        wait (phase_mode == 2);
        repeat (100) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (600) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_set(int y, int m, int mu, int d, int du);
        t_date_request rq;
        rq.req     = cal_pkg::ReqSet;
        rq.year    = 14'(y);
        rq.month   = 4'(m);
        rq.mon_unk = 1'(mu);
        rq.day     = 5'(d);
        rq.day_unk = 1'(du);
        rq.count   = 16'($urandom_range(0, 65535));
        request_q.insert(request_q.size(), rq);
        cycle_budget += 40;
    endtask

    // The date fields are ignored on an advance, so they carry random bits.
    task automatic push_advance(int n);
        t_date_request rq;
        rq.req     = cal_pkg::ReqAdvance;
        rq.year    = 14'($urandom_range(0, 16383));
        rq.month   = 4'($urandom_range(0, 15));
        rq.mon_unk = 1'($urandom_range(0, 1));
        rq.day     = 5'($urandom_range(0, 31));
        rq.day_unk = 1'($urandom_range(0, 1));
        rq.count   = 16'(n);
        request_q.insert(request_q.size(), rq);
        cycle_budget += n + 40;
    endtask

    function automatic int random_year();
        int edge_years[19] = '{0, 1, 99, 100, 399, 400, 1582, 1899, 1900, 1999,
                               2000, 2024, 2100, 4000, 8191, 8192, 9899, 9900, 9999};
        if ($urandom_range(0, 3) == 0) return edge_years[$urandom_range(0, 18)];
        return $urandom_range(0, 9999);
    endfunction

    // Mostly short steps; the long counts are rare because the block moves the
    // date by one day per cycle.
    function automatic int random_count();
        int r;
        r = $urandom_range(0, 999);
        if (r < 750) return $urandom_range(0, 40);
        if (r < 950) return $urandom_range(41, 600);
        if (r < 995) return $urandom_range(601, 3000);
        return $urandom_range(0, 65535);
    endfunction

    task automatic wait_drained();
        while (request_q.size() != 0 || s_axis_tvalid || expected_dates.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items);
        int made, pick, y, m, k;
        made = 0;
        while (made < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // A valid full date followed by one to three advances.
                y = random_year();
                m = $urandom_range(1, 12);
                push_set(y, m, 0,
                         ($urandom_range(0, 4) == 0) ? month_days(m, gregorian_leap(y))
                                                     : $urandom_range(1, month_days(m, gregorian_leap(y))),
                         0);
                k = $urandom_range(1, 3);
                repeat (k) push_advance(random_count());
                made += k + 1;
            end else if (pick < 62) begin
                // Close to a year end, often the last year of the range.
                y = ($urandom_range(0, 1) == 0) ? 9999 : random_year();
                push_set(y, 12, 0, $urandom_range(24, 31), 0);
                push_advance($urandom_range(1, 15));
                made += 2;
            end else if (pick < 75) begin
                k = $urandom_range(0, 1);
                push_set(random_year(), $urandom_range(0, 15), k, $urandom_range(0, 31),
                         k ? $urandom_range(0, 1) : 1);
                made++;
            end else if (pick < 90) begin
                push_set($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 1),
                         $urandom_range(0, 31), $urandom_range(0, 1));
                made++;
            end else begin
                push_advance(random_count());
                made++;
            end
        end
    endtask

    initial begin
        cal_now = '{year: 14'd0, month: 4'd0, day: 5'd0, doy: 9'd0, wday: cal_pkg::WdayUnk,
                    leap: 1'b1};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed corner dates.
        push_advance(5);                  // weekday unknown after reset
        push_set(0, 1, 0, 1, 0);
        push_set(9999, 12, 0, 31, 0);
        push_advance(1);                  // rolls over to year zero
        push_set(2000, 2, 0, 29, 0);
        push_set(1900, 2, 0, 29, 0);      // not a leap year: rejected
        push_set(2023, 2, 0, 29, 0);
        push_set(2024, 2, 0, 29, 0);
        push_advance(0);
        push_set(2024, 0, 0, 10, 0);
        push_set(2024, 13, 0, 10, 0);
        push_set(2024, 15, 0, 10, 0);
        push_set(2024, 4, 0, 31, 0);
        push_set(2024, 5, 0, 0, 0);
        push_set(2024, 1, 0, 31, 0);
        push_set(1600, 15, 1, 31, 1);     // month unknown, other fields ignored
        push_advance(3);
        push_set(2100, 7, 0, 0, 1);       // day unknown
        push_set(2100, 0, 0, 5, 1);       // day unknown but month still bad
        push_set(16383, 6, 0, 15, 0);
        push_set(10000, 3, 1, 3, 0);
        push_set(2023, 12, 0, 31, 0);
        push_advance(1);
        push_set(9999, 10, 0, 31, 0);
        push_advance(65535);
        wait_drained();

        tx_gap_pct   = 12;
        rx_stall_pct = 72;
        random_phase(600);
        wait_drained();

        tx_gap_pct   = 72;
        rx_stall_pct = 12;
        random_phase(600);
        wait_drained();

        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        phase_mode   = 2;
        random_phase(600);
        wait_drained();

        repeat (20) @(negedge i_clk);
        if (n_fail == 0 && expected_dates.size() == 0) begin
            $display("calendar_date_counter_tb: PASS");
        end else begin
            $display("calendar_date_counter_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/cal_pkg.sv
rtl/cal_day_step.sv
rtl/calendar_date_counter.sv
tb/calendar_date_counter_tb.sv
